@@ rtl/core/aftc_pkg.sv @@
`timescale 1ns / 1ps

package aftc_pkg;

    // shift-add multiplier: A operand, B operand (one bit per cycle), product
    localparam int MUL_AW = 24;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW + 1);

    // restoring divider: dividend/quotient width, divisor width
    localparam int DIV_W  = 34;
    localparam int DIV_DW = 17;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    localparam logic [23:0] ONE_G_Q8  = 24'd524288;
    localparam logic [16:0] UNIT_Q16  = 17'd65536;
    localparam logic [15:0] TAU_SM_RST = 16'd922;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MSQ  = 12'b0000_0000_0010,
        ST_SQRT = 12'b0000_0000_0100,
        ST_DIVI = 12'b0000_0000_1000,
        ST_ENV  = 12'b0000_0001_0000,
        ST_TGT  = 12'b0000_0010_0000,
        ST_SMO  = 12'b0000_0100_0000,
        ST_QM1  = 12'b0000_1000_0000,
        ST_QD1  = 12'b0001_0000_0000,
        ST_QM2  = 12'b0010_0000_0000,
        ST_QD2  = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } aftc_state_t;

    typedef enum logic [2:0] {
        REG_TAU_REST   = 3'd0,
        REG_TAU_GENTLE = 3'd1,
        REG_TAU_AGGR   = 3'd2,
        REG_DEV_THR    = 3'd3,
        REG_ATTACK     = 3'd4,
        REG_RELEASE    = 3'd5,
        REG_SMOOTH_DN  = 3'd6,
        REG_SMOOTH_UP  = 3'd7
    } aftc_reg_t;

endpackage

@@ rtl/core/aftc_mul.sv @@
`timescale 1ns / 1ps

// Unsigned shift-add multiplier, one bit of b per cycle.
module aftc_mul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [aftc_pkg::MUL_AW-1:0]      a,
    input  logic [aftc_pkg::MUL_BW-1:0]      b,
    output logic                             done,
    output logic [aftc_pkg::MUL_PW-1:0]      prod
);

    logic [aftc_pkg::MUL_PW-1:0] a_reg;
    logic [aftc_pkg::MUL_PW-1:0] acc_reg;
    logic [aftc_pkg::MUL_BW-1:0] b_reg;
    logic [aftc_pkg::MUL_CW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == aftc_pkg::MUL_CW'(aftc_pkg::MUL_BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= aftc_pkg::MUL_PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/core/aftc_div.sv @@
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module aftc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [aftc_pkg::DIV_W-1:0]    dividend,
    input  logic [aftc_pkg::DIV_DW-1:0]   divisor,
    output logic                          done,
    output logic [aftc_pkg::DIV_W-1:0]    quot
);

    logic [aftc_pkg::DIV_W-1:0]  q_reg;
    logic [aftc_pkg::DIV_DW-1:0] rem_reg;
    logic [aftc_pkg::DIV_DW-1:0] dvs_reg;
    logic [aftc_pkg::DIV_CW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [aftc_pkg::DIV_DW:0]   raw;
    logic                        fits;

    assign raw  = {rem_reg, q_reg[aftc_pkg::DIV_W-1]};
    assign fits = raw >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == aftc_pkg::DIV_CW'(aftc_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops safely
            rem_reg <= fits ? aftc_pkg::DIV_DW'(raw - {1'b0, dvs_reg})
                            : raw[aftc_pkg::DIV_DW-1:0];
            q_reg   <= {q_reg[aftc_pkg::DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ rtl/core/adaptive_filter_time_constant.sv @@
`timescale 1ns / 1ps

// channel   | ports                         | item contents (low bit first)
// ----------+-------------------------------+----------------------------------------
// input     | s_tvalid s_tready s_tdata/user| tdata: accel_x, accel_y, accel_z; tuser: at_rest
// result    | m_tvalid m_tready m_tdata/user| tdata: tau_out, motion_level; tuser: tau_changed
// config    | APB psel penable pwrite ...   | eight registers at byte address 4*i
//
// One item is worked through before the next is accepted, by the serial arithmetic: three
// squares, a 24-step square root, a 34-step division, three envelope/target/smoothing
// products and, for the quantiser, two more products and two more divisions, all on one
// shared multiplier and one shared divider, with an idle and a done state around them.
// At rest the target product is skipped; a span too small to quantise drops the quantiser.
// Reset (aresetn low at a clock edge) restores the registers and filter state.
// The result register holds an item while m_tready is low; the next input item
// is taken meanwhile and its result waits at the end of its work.
module adaptive_filter_time_constant #(
    parameter int TAU_LEVELS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // at_rest[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tau_out[15:0], motion_level[32:16], zero pad[39:33]
    output logic [39:0] m_tdata,
    // tau_changed[0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEVELS_EFF = (TAU_LEVELS < 1) ? 1 : TAU_LEVELS;
    // span*1000 > 256*L  <=>  span > floor(256*L/1000)
    localparam int SPAN_MIN   = (256 * LEVELS_EFF) / 1000;
    localparam logic [16:0] LEV17 = 17'(LEVELS_EFF);

    // configuration registers
    logic [15:0] tau_rest_reg, tau_gentle_reg, tau_aggr_reg, dev_thr_reg;
    logic [16:0] attack_reg, release_reg, smooth_dn_reg, smooth_up_reg;

    aftc_pkg::aftc_state_t state_reg, state_next;
    logic        issued_reg;
    logic [1:0]  axis_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic        rest_reg;
    logic [31:0] sum_reg;
    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [16:0] inst_reg, env_reg;
    logic [15:0] target_reg, sm_reg;
    logic [15:0] qo_reg;
    logic [15:0] applied_reg;
    logic        applied_valid_reg;
    logic        m_valid_reg;
    logic [15:0] tau_out_reg;
    logic [16:0] motion_reg;
    logic        changed_reg;

    // shared serial units
    logic                          mul_start, mul_done;
    logic [aftc_pkg::MUL_AW-1:0]   mul_a;
    logic [aftc_pkg::MUL_BW-1:0]   mul_b;
    logic [aftc_pkg::MUL_PW-1:0]   mul_p;
    logic                          div_start, div_done;
    logic [aftc_pkg::DIV_W-1:0]    div_n, div_q;
    logic [aftc_pkg::DIV_DW-1:0]   div_d;

    aftc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_p)
    );

    aftc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_n), .divisor(div_d), .done(div_done), .quot(div_q)
    );

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return w[16] ? 17'(-w) : 17'(w);
    endfunction

    function automatic logic [16:0] sat_rate(input logic [16:0] r);
        return (r > aftc_pkg::UNIT_Q16) ? aftc_pkg::UNIT_Q16 : r;
    endfunction

    // ---------------------------------------------------------------- derived values
    logic [16:0] axis_mag;
    logic [23:0] dev8;
    logic [15:0] thr_eff;
    logic        env_up;
    logic [16:0] env_rate, env_diff;
    logic        aggr_lo;
    logic [15:0] tg_diff;
    logic        sm_up;
    logic [16:0] sm_rate;
    logic [15:0] sm_diff;
    logic [15:0] lo, hi, span;
    logic        sm_below;
    logic [15:0] sm_off;
    logic [16:0] rnd;
    logic [27:0] sq_raw;
    logic [25:0] sq_trial;
    logic [31:0] sum_new;
    logic [16:0] inst_new;
    logic [16:0] env_new;
    logic [17:0] tgt_new, smo_new;
    logic [34:0] q_sum;
    logic [15:0] q_final;

    always_comb begin
        case (axis_reg)
            2'd0:    axis_mag = abs16(ax_reg);
            2'd1:    axis_mag = abs16(ay_reg);
            default: axis_mag = abs16(az_reg);
        endcase
    end

    assign dev8    = (root_reg >= aftc_pkg::ONE_G_Q8) ? root_reg - aftc_pkg::ONE_G_Q8
                                                      : aftc_pkg::ONE_G_Q8 - root_reg;
    assign thr_eff = (dev_thr_reg == 16'd0) ? 16'd1 : dev_thr_reg;

    assign env_up   = inst_reg > env_reg;
    assign env_rate = env_up ? sat_rate(attack_reg) : sat_rate(release_reg);
    assign env_diff = env_up ? inst_reg - env_reg : env_reg - inst_reg;

    assign aggr_lo = tau_aggr_reg < tau_gentle_reg;
    assign tg_diff = aggr_lo ? tau_gentle_reg - tau_aggr_reg : tau_aggr_reg - tau_gentle_reg;

    assign sm_up   = target_reg >= sm_reg;
    assign sm_rate = sm_up ? sat_rate(smooth_up_reg) : sat_rate(smooth_dn_reg);
    assign sm_diff = sm_up ? target_reg - sm_reg : sm_reg - target_reg;

    always_comb begin
        lo = tau_rest_reg;
        hi = tau_rest_reg;
        if (tau_gentle_reg < lo) lo = tau_gentle_reg;
        if (tau_aggr_reg < lo)   lo = tau_aggr_reg;
        if (tau_gentle_reg > hi) hi = tau_gentle_reg;
        if (tau_aggr_reg > hi)   hi = tau_aggr_reg;
    end
    assign span     = hi - lo;
    assign sm_below = sm_reg < lo;
    assign sm_off   = sm_below ? lo - sm_reg : sm_reg - lo;

    // product / 65536 rounded to nearest, halves away from zero (on the magnitude)
    assign rnd = mul_p[32:16] + 17'(mul_p[15]);

    assign sq_raw   = {rem_reg, rad_reg[47:46]};
    assign sq_trial = {root_reg, 2'b01};

    assign sum_new  = sum_reg + mul_p[31:0];
    assign inst_new = (div_q > aftc_pkg::DIV_W'(aftc_pkg::UNIT_Q16))
                      ? aftc_pkg::UNIT_Q16 : div_q[16:0];
    assign env_new  = env_up ? env_reg + rnd : env_reg - rnd;
    assign tgt_new  = aggr_lo ? {2'b0, tau_gentle_reg} - {1'b0, rnd}
                              : {2'b0, tau_gentle_reg} + {1'b0, rnd};
    assign smo_new  = sm_up ? {2'b0, sm_reg} + {1'b0, rnd}
                            : {2'b0, sm_reg} - {1'b0, rnd};

    // negative offset rounds to lo or below: clamp to lo
    assign q_sum   = {19'b0, lo} + {1'b0, div_q};
    assign q_final = sm_below ? lo
                   : (q_sum > {19'b0, hi}) ? hi : q_sum[15:0];

    // ---------------------------------------------------------------- unit operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        unique case (state_reg)
            aftc_pkg::ST_MSQ: begin
                mul_a = aftc_pkg::MUL_AW'(axis_mag);
                mul_b = axis_mag;
            end
            aftc_pkg::ST_DIVI: begin
                div_n = aftc_pkg::DIV_W'({dev8, 8'b0});
                div_d = {1'b0, thr_eff};
            end
            aftc_pkg::ST_ENV: begin
                mul_a = aftc_pkg::MUL_AW'(env_rate);
                mul_b = env_diff;
            end
            aftc_pkg::ST_TGT: begin
                mul_a = aftc_pkg::MUL_AW'(tg_diff);
                mul_b = env_reg;
            end
            aftc_pkg::ST_SMO: begin
                mul_a = aftc_pkg::MUL_AW'(sm_rate);
                mul_b = {1'b0, sm_diff};
            end
            aftc_pkg::ST_QM1: begin
                mul_a = aftc_pkg::MUL_AW'(sm_off);
                mul_b = LEV17;
            end
            aftc_pkg::ST_QD1: begin
                // k = (2*d*L + span) / (2*span)
                div_n = {mul_p[32:0], 1'b0} + aftc_pkg::DIV_W'(span);
                div_d = {span, 1'b0};
            end
            aftc_pkg::ST_QM2: begin
                mul_a = div_q[aftc_pkg::MUL_AW-1:0];
                mul_b = {1'b0, span};
            end
            aftc_pkg::ST_QD2: begin
                div_n = {mul_p[32:0], 1'b0} + aftc_pkg::DIV_W'(LEV17);
                div_d = {LEV17[15:0], 1'b0};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    logic is_mul_state, is_div_state, skip_tgt;
    assign skip_tgt     = (state_reg == aftc_pkg::ST_TGT) && rest_reg;
    assign is_mul_state = (state_reg == aftc_pkg::ST_MSQ) || (state_reg == aftc_pkg::ST_ENV)
                       || (state_reg == aftc_pkg::ST_TGT) || (state_reg == aftc_pkg::ST_SMO)
                       || (state_reg == aftc_pkg::ST_QM1) || (state_reg == aftc_pkg::ST_QM2);
    assign is_div_state = (state_reg == aftc_pkg::ST_DIVI) || (state_reg == aftc_pkg::ST_QD1)
                       || (state_reg == aftc_pkg::ST_QD2);
    // fire each unit once on entry to its state
    assign mul_start = is_mul_state && !issued_reg && !skip_tgt;
    assign div_start = is_div_state && !issued_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aftc_pkg::ST_IDLE: if (s_tvalid) state_next = aftc_pkg::ST_MSQ;
            aftc_pkg::ST_MSQ:  if (mul_done && axis_reg == 2'd2) state_next = aftc_pkg::ST_SQRT;
            aftc_pkg::ST_SQRT: if (sq_cnt_reg == 5'd23) state_next = aftc_pkg::ST_DIVI;
            aftc_pkg::ST_DIVI: if (div_done) state_next = aftc_pkg::ST_ENV;
            aftc_pkg::ST_ENV:  if (mul_done) state_next = aftc_pkg::ST_TGT;
            aftc_pkg::ST_TGT:  if (skip_tgt || mul_done) state_next = aftc_pkg::ST_SMO;
            aftc_pkg::ST_SMO: begin
                if (mul_done) begin
                    state_next = (32'(span) > 32'(SPAN_MIN)) ? aftc_pkg::ST_QM1
                                                             : aftc_pkg::ST_DONE;
                end
            end
            aftc_pkg::ST_QM1:  if (mul_done) state_next = aftc_pkg::ST_QD1;
            aftc_pkg::ST_QD1:  if (div_done) state_next = aftc_pkg::ST_QM2;
            aftc_pkg::ST_QM2:  if (mul_done) state_next = aftc_pkg::ST_QD2;
            aftc_pkg::ST_QD2:  if (div_done) state_next = aftc_pkg::ST_DONE;
            aftc_pkg::ST_DONE: if (out_free) state_next = aftc_pkg::ST_IDLE;
            default:           state_next = aftc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= aftc_pkg::ST_IDLE;
            issued_reg        <= 1'b0;
            axis_reg          <= 2'd0;
            sq_cnt_reg        <= 5'd0;
            env_reg           <= '0;
            sm_reg            <= aftc_pkg::TAU_SM_RST;
            applied_reg       <= '0;
            applied_valid_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end else if (mul_done || div_done) begin
                issued_reg <= 1'b0;
            end

            // load a new result, else drop the one just taken
            if (state_reg == aftc_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                aftc_pkg::ST_IDLE: begin
                    axis_reg <= 2'd0;
                end
                aftc_pkg::ST_MSQ: begin
                    if (mul_done) axis_reg <= axis_reg + 2'd1;
                end
                aftc_pkg::ST_SQRT: begin
                    sq_cnt_reg <= (sq_cnt_reg == 5'd23) ? 5'd0 : sq_cnt_reg + 5'd1;
                end
                aftc_pkg::ST_ENV: begin
                    if (mul_done) env_reg <= env_new;
                end
                aftc_pkg::ST_SMO: begin
                    if (mul_done) sm_reg <= smo_new[15:0];
                end
                aftc_pkg::ST_DONE: begin
                    if (out_free) begin
                        if (!applied_valid_reg || qo_reg != applied_reg) begin
                            applied_reg       <= qo_reg;
                            applied_valid_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                    applied_valid_reg <= applied_valid_reg;
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            aftc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ax_reg   <= s_tdata[15:0];
                    ay_reg   <= s_tdata[31:16];
                    az_reg   <= s_tdata[47:32];
                    rest_reg <= s_tuser;
                    sum_reg  <= '0;
                end
            end
            aftc_pkg::ST_MSQ: begin
                if (mul_done) begin
                    sum_reg  <= sum_new;
                    rad_reg  <= {sum_new, 16'b0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            aftc_pkg::ST_SQRT: begin
                // one result bit per cycle, two radicand bits shifted in
                rad_reg <= rad_reg << 2;
                if (sq_raw >= {2'b0, sq_trial}) begin
                    rem_reg  <= 26'(sq_raw - {2'b0, sq_trial});
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= sq_raw[25:0];
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            aftc_pkg::ST_DIVI: begin
                if (div_done) inst_reg <= inst_new;
            end
            aftc_pkg::ST_TGT: begin
                if (skip_tgt) begin
                    target_reg <= tau_rest_reg;
                end else if (mul_done) begin
                    target_reg <= tgt_new[15:0];
                end
            end
            aftc_pkg::ST_SMO: begin
                if (mul_done) qo_reg <= smo_new[15:0];
            end
            aftc_pkg::ST_QD2: begin
                if (div_done) qo_reg <= q_final;
            end
            aftc_pkg::ST_DONE: begin
                if (out_free) begin
                    tau_out_reg <= qo_reg;
                    motion_reg  <= env_reg;
                    changed_reg <= !applied_valid_reg || qo_reg != applied_reg;
                end
            end
            default: begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == aftc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, motion_reg, tau_out_reg};
    assign m_tuser  = changed_reg;

    // ---------------------------------------------------------------- register port
    logic [2:0] reg_idx;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_rest_reg   <= 16'd1536;
            tau_gentle_reg <= 16'd1485;
            tau_aggr_reg   <= 16'd768;
            dev_thr_reg    <= 16'd627;
            attack_reg     <= 17'd9830;
            release_reg    <= 17'd524;
            smooth_dn_reg  <= 17'd262;
            smooth_up_reg  <= 17'd524;
        end else if (psel && penable && pwrite && pready) begin
            unique case (aftc_pkg::aftc_reg_t'(reg_idx))
                aftc_pkg::REG_TAU_REST:   tau_rest_reg   <= pwdata[15:0];
                aftc_pkg::REG_TAU_GENTLE: tau_gentle_reg <= pwdata[15:0];
                aftc_pkg::REG_TAU_AGGR:   tau_aggr_reg   <= pwdata[15:0];
                aftc_pkg::REG_DEV_THR:    dev_thr_reg    <= pwdata[15:0];
                aftc_pkg::REG_ATTACK:     attack_reg     <= pwdata[16:0];
                aftc_pkg::REG_RELEASE:    release_reg    <= pwdata[16:0];
                aftc_pkg::REG_SMOOTH_DN:  smooth_dn_reg  <= pwdata[16:0];
                aftc_pkg::REG_SMOOTH_UP:  smooth_up_reg  <= pwdata[16:0];
                default:                  tau_rest_reg   <= tau_rest_reg;
            endcase
        end
    end

    always_comb begin
        unique case (aftc_pkg::aftc_reg_t'(reg_idx))
            aftc_pkg::REG_TAU_REST:   prdata = {16'b0, tau_rest_reg};
            aftc_pkg::REG_TAU_GENTLE: prdata = {16'b0, tau_gentle_reg};
            aftc_pkg::REG_TAU_AGGR:   prdata = {16'b0, tau_aggr_reg};
            aftc_pkg::REG_DEV_THR:    prdata = {16'b0, dev_thr_reg};
            aftc_pkg::REG_ATTACK:     prdata = {15'b0, attack_reg};
            aftc_pkg::REG_RELEASE:    prdata = {15'b0, release_reg};
            aftc_pkg::REG_SMOOTH_DN:  prdata = {15'b0, smooth_dn_reg};
            aftc_pkg::REG_SMOOTH_UP:  prdata = {15'b0, smooth_up_reg};
            default:                  prdata = '0;
        endcase
    end

endmodule
